// ----- hw/rtl/uptvd_pkg.sv -----
// Types and constants shared by the upwind TVD convection assembly.
// Holds the input and result item structures and the limiter mode codes.
// No dependencies.
package uptvd_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_UPWIND   = 2'd0;
    localparam mode_t MODE_VAN_LEER = 2'd1;
    localparam mode_t MODE_MINMOD   = 2'd2;
    // The unused code behaves as plain upwind.
    localparam mode_t MODE_SPARE    = 2'd3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               cell_active;
        logic               has_north;
        logic               has_south;
        logic signed [31:0] flux_east;
        logic signed [31:0] flux_west;
        logic signed [31:0] flux_north;
        logic signed [31:0] flux_south;
        logic signed [31:0] phi_west_two;
        logic signed [31:0] phi_west_one;
        logic signed [31:0] phi_centre;
        logic signed [31:0] phi_east_one;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] add_diag;
        logic signed [31:0] add_east;
        logic signed [31:0] add_west;
        logic signed [31:0] add_north;
        logic signed [31:0] add_south;
        logic signed [31:0] add_rhs;
    } out_item_t;

    // Upwind coefficients of one cell, carried alongside the limiter pipeline.
    typedef struct packed {
        logic               active;
        logic signed [31:0] diag;
        logic signed [31:0] east;
        logic signed [31:0] west;
        logic signed [31:0] north;
        logic signed [31:0] south;
    } coef_t;

endpackage

// ----- hw/rtl/upwind_tvd_convection_assembly.sv -----
// Top level of the upwind convection assembly with TVD deferred correction.
// Depends on uptvd_pkg and the pipelined divider uptvd_div.
//
// This block takes one cell item in every clock cycle and returns one result item per cell:
// the five upwind coefficient increments and, in Van Leer or minmod mode, the deferred
// correction of the east and west faces. The depth of the pipeline comes mainly from three
// bit-per-stage dividers in series: the gradient ratio, its inverse for negative flux and
// the Van Leer quotient. Every stage moves together; the whole pipeline pauses only while a
// finished item waits on the result channel and is not taken, and the input channel keeps
// accepting items while earlier ones are still in flight.
// The limiter mode is written through the configuration channel, which is always ready, and
// should only be changed while no item is in flight.
module upwind_tvd_convection_assembly
    import uptvd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int F      = FRAC_BITS;
    localparam int N1     = 33 + F;          // ratio dividend width
    localparam int N2     = 2 * F + 1;       // inverse dividend width
    localparam int N3     = 32 + F;          // Van Leer dividend width
    localparam int Q3     = F + 1;           // Van Leer quotient width
    localparam int PSI_W  = F + 2;
    localparam int PROD_W = F + 36;
    localparam int SW1    = 67;
    localparam int SW2    = 97;
    localparam int DLY    = N1 + N2 + Q3 + 6;

    localparam logic [31:0]       ONE_U   = 32'd1 << F;
    localparam logic signed [31:0] ONE_S  = 32'sd1 <<< F;
    localparam logic [PSI_W-1:0]  PSI_ONE = PSI_W'(1) << F;
    localparam logic [PSI_W-1:0]  PSI_MAX = PSI_W'(1) << (F + 1);

    function automatic logic [31:0] pos32(input logic signed [31:0] x);
        return x[31] ? 32'd0 : x;
    endfunction

    function automatic logic [32:0] negpos(input logic signed [31:0] x);
        return x[31] ? (33'd0 - {x[31], x}) : 33'd0;
    endfunction

    function automatic logic signed [31:0] satu(input logic [34:0] x);
        return (x > 35'h0_7FFF_FFFF) ? S32_MAX : x[31:0];
    endfunction

    // Global advance: the output register is empty or its item is taken now.
    logic en;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    mode_t mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_UPWIND;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Upwind coefficients: computed on entry and delayed to meet the TVD
    // correction at the output.
    // ------------------------------------------------------------------
    coef_t coef_next;
    coef_t cm_reg [DLY+1];

    always_comb begin
        logic signed [31:0] fn;
        logic signed [31:0] fs;
        logic [34:0]        diag;
        fn   = s_data.has_north ? s_data.flux_north : 32'sd0;
        fs   = s_data.has_south ? s_data.flux_south : 32'sd0;
        diag = 35'(pos32(s_data.flux_east)) + 35'(negpos(s_data.flux_west))
             + 35'(pos32(fn)) + 35'(negpos(fs));
        coef_next.active = s_data.cell_active;
        coef_next.diag   = satu(diag);
        coef_next.east   = satu(35'(negpos(s_data.flux_east)));
        coef_next.west   = pos32(s_data.flux_west);
        coef_next.north  = s_data.has_north ? satu(35'(negpos(fn))) : 32'sd0;
        coef_next.south  = s_data.has_south ? pos32(fs) : 32'sd0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cm_reg[0] <= coef_next;
            for (int k = 0; k < DLY; k++) begin
                cm_reg[k+1] <= cm_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of the stages outside the dividers.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, m_valid_reg;
    logic d1_vld [2];
    logic d2_vld [2];
    logic d3_vld [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= d1_vld[0];
            v3_reg      <= d2_vld[0];
            v4_reg      <= d3_vld[0];
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            m_valid_reg <= v7_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Face pipelines. Face 0 is the east face, face 1 the west face.
    // ------------------------------------------------------------------
    logic [32:0]        s1_nmag_reg [2];
    logic [32:0]        s1_dmag_reg [2];
    logic [SW1-1:0]     s1_side_reg [2];
    logic [N1-1:0]      d1_q    [2];
    logic [SW1-1:0]     d1_side [2];
    logic signed [31:0] s2_r_reg [2];
    logic [SW2-1:0]     s2_side_reg [2];
    logic [N2-1:0]      d2_q    [2];
    logic [SW2-1:0]     d2_side [2];
    logic signed [31:0] s3_rf_reg [2];
    logic [SW2-1:0]     s3_side_reg [2];
    logic [Q3-1:0]      d3_q    [2];
    logic [SW2-1:0]     d3_side [2];
    logic signed [31:0] s4_flux_reg  [2];
    logic signed [32:0] s4_upfar_reg [2];
    logic [PSI_W-1:0]   s4_psi_reg   [2];
    logic signed [31:0] s5_flux_reg  [2];
    logic signed [PROD_W-1:0] s5_prod_reg [2];
    logic signed [31:0] s6_flux_reg  [2];
    logic signed [31:0] s6_corr_reg  [2];
    logic signed [63:0] s7_term_reg  [2];

    for (genvar f = 0; f < 2; f++) begin : g_face
        logic signed [31:0] inner, outer, far_v, flux_v, up_v;
        logic signed [32:0] den_c, num_c, upfar_c;
        logic signed [31:0] r_c, rinv_c, rf_c, rpos_c;
        logic [31:0]        rmag_c;
        logic [63:0]        q1w, q2w;
        logic [PSI_W-1:0]   psi_c;
        logic signed [PROD_W-1:0] prod_c, sh_c;
        logic signed [63:0] sh64;
        logic signed [31:0] corr_c;

        if (f == 0) begin : g_east
            assign inner  = s_data.phi_centre;
            assign outer  = s_data.phi_east_one;
            assign far_v  = s_data.phi_west_one;
            assign flux_v = s_data.flux_east;
        end else begin : g_west
            assign inner  = s_data.phi_west_one;
            assign outer  = s_data.phi_centre;
            assign far_v  = s_data.phi_west_two;
            assign flux_v = s_data.flux_west;
        end

        // Stage 1: differences and magnitudes for the gradient ratio.
        always_comb begin
            up_v    = flux_v[31] ? outer : inner;
            den_c   = {inner[31], inner} - {far_v[31], far_v};
            num_c   = {outer[31], outer} - {inner[31], inner};
            upfar_c = {up_v[31], up_v} - {far_v[31], far_v};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s1_nmag_reg[f] <= num_c[32] ? (33'd0 - num_c) : num_c;
                s1_dmag_reg[f] <= den_c[32] ? (33'd0 - den_c) : den_c;
                s1_side_reg[f] <= {flux_v, upfar_c, num_c[32] ^ den_c[32], den_c == 33'sd0};
            end
        end

        uptvd_div #(.NW(N1), .DW(33), .QW(N1), .SW(SW1)) u_div_ratio (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v1_reg),
            .dividend  ({s1_nmag_reg[f], {F{1'b0}}}),
            .divisor   (s1_dmag_reg[f]),
            .side_in   (s1_side_reg[f]),
            .out_valid (d1_vld[f]),
            .quotient  (d1_q[f]),
            .side_out  (d1_side[f])
        );

        // Stage 2: signed, saturated ratio; a zero denominator gives zero.
        always_comb begin
            q1w = 64'(d1_q[f]);
            if (d1_side[f][0]) begin
                r_c = 32'sd0;
            end else if (d1_side[f][1]) begin
                r_c = (q1w > 64'h8000_0000) ? S32_MIN : 32'(64'd0 - q1w);
            end else begin
                r_c = (q1w > 64'h7FFF_FFFF) ? S32_MAX : q1w[31:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s2_r_reg[f]    <= r_c;
                s2_side_reg[f] <= {d1_side[f][66:2], r_c};
            end
        end

        assign rmag_c = s2_r_reg[f][31] ? (~s2_r_reg[f] + 32'd1) : s2_r_reg[f];

        uptvd_div #(.NW(N2), .DW(32), .QW(N2), .SW(SW2)) u_div_inverse (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v2_reg),
            .dividend  ({1'b1, {(2 * F){1'b0}}}),
            .divisor   (rmag_c),
            .side_in   (s2_side_reg[f]),
            .out_valid (d2_vld[f]),
            .quotient  (d2_q[f]),
            .side_out  (d2_side[f])
        );

        // Stage 3: against a negative flux the ratio is inverted.
        always_comb begin
            q2w = 64'(d2_q[f]);
            if (d2_side[f][31:0] == 32'd0) begin
                rinv_c = S32_MAX;
            end else if (d2_side[f][31]) begin
                rinv_c = (q2w > 64'h8000_0000) ? S32_MIN : 32'(64'd0 - q2w);
            end else begin
                rinv_c = (q2w > 64'h7FFF_FFFF) ? S32_MAX : q2w[31:0];
            end
            rf_c = d2_side[f][96] ? rinv_c : d2_side[f][31:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s3_rf_reg[f]   <= rf_c;
                s3_side_reg[f] <= {d2_side[f][96:32], rf_c};
            end
        end

        assign rpos_c = s3_rf_reg[f][31] ? 32'sd0 : s3_rf_reg[f];

        uptvd_div #(.NW(N3), .DW(32), .QW(Q3), .SW(SW2)) u_div_vanleer (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v3_reg),
            .dividend  ({rpos_c[30:0], {(F + 1){1'b0}}}),
            .divisor   (ONE_U + rpos_c),
            .side_in   (s3_side_reg[f]),
            .out_valid (d3_vld[f]),
            .quotient  (d3_q[f]),
            .side_out  (d3_side[f])
        );

        // Stage 4: limiter value psi.
        always_comb begin
            logic signed [31:0] rf;
            rf = d3_side[f][31:0];
            case (mode_reg)
                MODE_VAN_LEER: begin
                    psi_c = (rf <= 32'sd0) ? '0 : PSI_W'(d3_q[f]);
                end
                MODE_MINMOD: begin
                    if (rf < 32'sd0) begin
                        psi_c = '0;
                    end else if (rf > ONE_S) begin
                        psi_c = PSI_ONE;
                    end else begin
                        psi_c = PSI_W'(rf);
                    end
                end
                default: begin
                    psi_c = '0;
                end
            endcase
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s4_flux_reg[f]  <= d3_side[f][96:65];
                s4_upfar_reg[f] <= d3_side[f][64:32];
                s4_psi_reg[f]   <= psi_c;
            end
        end

        // Stage 5: psi times the upwind difference.
        assign prod_c = $signed({1'b0, s4_psi_reg[f]}) * s4_upfar_reg[f];

        always_ff @(posedge aclk) begin
            if (en) begin
                s5_flux_reg[f] <= s4_flux_reg[f];
                s5_prod_reg[f] <= prod_c;
            end
        end

        // Stage 6: halve, rescale with floor and saturate the correction.
        always_comb begin
            sh_c = s5_prod_reg[f] >>> (F + 1);
            sh64 = 64'(sh_c);
            if (sh64 > 64'sh7FFF_FFFF) begin
                corr_c = S32_MAX;
            end else if (sh64 < -64'sh8000_0000) begin
                corr_c = S32_MIN;
            end else begin
                corr_c = sh64[31:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s6_flux_reg[f] <= s5_flux_reg[f];
                s6_corr_reg[f] <= corr_c;
            end
        end

        // Stage 7: face flux times correction.
        always_ff @(posedge aclk) begin
            if (en) begin
                s7_term_reg[f] <= s6_flux_reg[f] * s6_corr_reg[f];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: west term minus east term, saturated.
    // ------------------------------------------------------------------
    logic signed [63:0] rhs_wide;
    logic signed [31:0] rhs_sat;
    logic               tvd_on;
    out_item_t          m_data_reg;

    always_comb begin
        rhs_wide = (s7_term_reg[1] >>> F) - (s7_term_reg[0] >>> F);
        if (rhs_wide > 64'sh7FFF_FFFF) begin
            rhs_sat = S32_MAX;
        end else if (rhs_wide < -64'sh8000_0000) begin
            rhs_sat = S32_MIN;
        end else begin
            rhs_sat = rhs_wide[31:0];
        end
        tvd_on = (mode_reg == MODE_VAN_LEER) || (mode_reg == MODE_MINMOD);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (cm_reg[DLY].active) begin
                m_data_reg.add_diag  <= cm_reg[DLY].diag;
                m_data_reg.add_east  <= cm_reg[DLY].east;
                m_data_reg.add_west  <= cm_reg[DLY].west;
                m_data_reg.add_north <= cm_reg[DLY].north;
                m_data_reg.add_south <= cm_reg[DLY].south;
                m_data_reg.add_rhs   <= tvd_on ? rhs_sat : 32'sd0;
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_data = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Both face pipelines must carry the same item in the same stage.
    a_face_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (d1_vld[0] == d1_vld[1]) && (d2_vld[0] == d2_vld[1]) && (d3_vld[0] == d3_vld[1]))
        else $error("east and west face pipelines out of step");

    // The limiter never exceeds two in either mode.
    a_psi_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (s4_psi_reg[0] <= PSI_MAX) && (s4_psi_reg[1] <= PSI_MAX))
        else $error("limiter value out of range");

    // A result waiting on the output freezes the whole pipeline.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(v7_reg) && $stable(s7_term_reg[0])))
        else $error("pipeline moved during an output stall");

endmodule

// ----- hw/rtl/uptvd_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Carries a valid bit and a sideband vector alongside; no package dependency.
module uptvd_div #(
    parameter int NW = 49,
    parameter int DW = 33,
    parameter int QW = 49,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    // The quotient must fit in QW bits, so the dividend bits above QW start
    // out as a partial remainder smaller than the divisor.
    logic [DW-1:0] rem_c  [QW];
    logic [QW-1:0] lo_c   [QW];
    logic [QW-1:0] quo_c  [QW];
    logic [DW-1:0] dvs_c  [QW];
    logic [SW-1:0] side_c [QW];
    logic          vld_c  [QW];

    logic [DW-1:0] rem_reg  [1:QW-1];
    logic [QW-1:0] lo_reg   [1:QW-1];
    logic [DW-1:0] dvs_reg  [1:QW-1];
    logic [QW-1:0] quo_reg  [1:QW];
    logic [SW-1:0] side_reg [1:QW];
    logic          vld_reg  [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_c[0]  = DW'(dividend >> QW);
            assign lo_c[0]   = dividend[QW-1:0];
            assign quo_c[0]  = '0;
            assign dvs_c[0]  = divisor;
            assign side_c[0] = side_in;
            assign vld_c[0]  = in_valid;
        end else begin : g_mid
            assign rem_c[k]  = rem_reg[k];
            assign lo_c[k]   = lo_reg[k];
            assign quo_c[k]  = quo_reg[k];
            assign dvs_c[k]  = dvs_reg[k];
            assign side_c[k] = side_reg[k];
            assign vld_c[k]  = vld_reg[k];
        end

        always_comb begin
            trial    = {rem_c[k], lo_c[k][QW-1]};
            ge       = (trial >= {1'b0, dvs_c[k]});
            rem_next = ge ? DW'(trial - {1'b0, dvs_c[k]}) : trial[DW-1:0];
            quo_next = {quo_c[k][QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_c[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k+1]  <= quo_next;
                side_reg[k+1] <= side_c[k];
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next;
                    lo_reg[k+1]  <= {lo_c[k][QW-2:0], 1'b0};
                    dvs_reg[k+1] <= dvs_c[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quotient  = quo_reg[QW];
    assign side_out  = side_reg[QW];

endmodule
